FILE: rtl/multi_mode_task_timer_macros.svh
// Assertion macros for the multi-mode task timer
`ifndef MULTI_MODE_TASK_TIMER_MACROS_SVH
`define MULTI_MODE_TASK_TIMER_MACROS_SVH
// Assert that a condition implies a consequence in the same cycle
`define MMTT_ASSERT_IMPL(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle
`define MMTT_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/mmtt_pkg.sv
// Package: widths, codes and the shared command type of the multi-mode task timer
`default_nettype none
package mmtt_pkg;
  localparam int SLOTS = 16;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int TIME_BITS = 32;
  localparam int QDEPTH = 2;

  localparam logic [2:0] FN_TICK = 3'd0;
  localparam logic [2:0] FN_ONCE = 3'd1;
  localparam logic [2:0] FN_DUR = 3'd2;
  localparam logic [2:0] FN_PER = 3'd3;
  localparam logic [2:0] FN_CHAIN = 3'd4;
  localparam logic [2:0] FN_CANCEL = 3'd5;
  localparam logic [2:0] FN_PAUSE = 3'd6;
  localparam logic [2:0] FN_RESUME = 3'd7;

  localparam logic [2:0] EV_FIRED = 3'd0;
  localparam logic [2:0] EV_DURATION = 3'd1;
  localparam logic [2:0] EV_ACCEPT = 3'd2;
  localparam logic [2:0] EV_REJECT = 3'd3;
  localparam logic [2:0] EV_DONE = 3'd4;

  localparam logic [1:0] MODE_ONCE = 2'd1;
  localparam logic [1:0] MODE_DURATION = 2'd2;
  localparam logic [1:0] MODE_PERIODIC = 2'd3;

  // Classified command handed from front to back
  typedef struct packed {
    logic [2:0] func;
    logic [3:0] target_slot;
    logic target_ok;
    logic [TIME_BITS-1:0] amount;
  } cmd_t;
endpackage
`default_nettype wire

FILE: rtl/mmtt_front.sv
// Front end: takes commands, classifies them and queues them for the engine
`default_nettype none
module mmtt_front (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic [2:0] func,
  input wire logic [3:0] target_slot,
  input wire logic [31:0] amount,
  output logic busy,
  output logic q_valid,
  output mmtt_pkg::cmd_t q_head,
  input wire logic q_pop
);
  localparam int QB = $clog2(mmtt_pkg::QDEPTH);
  mmtt_pkg::cmd_t q_mem [mmtt_pkg::QDEPTH];
  logic [QB-1:0] rd_ptr;
  logic [QB-1:0] wr_ptr;
  logic [QB:0] count;
  logic push;
  mmtt_pkg::cmd_t cmd_in;

  // Accept one item into the queue when not full
  assign busy = (count == (QB+1)'(mmtt_pkg::QDEPTH));
  assign push = start && !busy;
  assign q_valid = (count != '0);
  assign q_head = q_mem[rd_ptr];

  // Range check of the target id
  always_comb begin
    cmd_in.func = func;
    cmd_in.target_slot = target_slot;
    cmd_in.target_ok = ({1'b0, target_slot} < 5'(mmtt_pkg::SLOTS));
    cmd_in.amount = amount[mmtt_pkg::TIME_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd_in;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QB+1)'(push) - (QB+1)'(q_pop);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/mmtt_back.sv
// Back end: slot table, command execution and tick sweep over the slots
`default_nettype none
module mmtt_back (
  input wire logic clk,
  input wire logic rst,
  input wire logic q_valid,
  input wire mmtt_pkg::cmd_t q_head,
  output logic q_pop,
  output logic event_valid,
  output logic [2:0] event_kind,
  output logic [3:0] event_slot,
  output logic last_of_run
);
  localparam int SB = mmtt_pkg::SLOT_BITS;
  localparam int TB = mmtt_pkg::TIME_BITS;
  localparam int SLOTS_W = mmtt_pkg::SLOTS;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SWEEP = 3'b010,
    ST_EXEC = 3'b100
  } state_t;

  state_t state;
  logic [SLOTS_W-1:0] slot_valid;
  logic [1:0] slot_mode [mmtt_pkg::SLOTS];
  logic slot_paused [mmtt_pkg::SLOTS];
  logic [TB-1:0] slot_remaining [mmtt_pkg::SLOTS];
  logic [TB-1:0] slot_period [mmtt_pkg::SLOTS];

  mmtt_pkg::cmd_t cmd;
  logic [SB-1:0] idx;
  logic [SB-1:0] tgt;
  logic free_found;
  logic [SB-1:0] free_idx;
  logic known;
  logic [TB:0] sum;
  logic [TB-1:0] chain_time;
  logic [TB-1:0] rem;
  logic dt_ge;
  logic dt_le;

  assign tgt = cmd.target_slot[SB-1:0];
  assign known = cmd.target_ok && slot_valid[tgt];
  assign q_pop = (state == ST_IDLE) && q_valid;
  assign rem = slot_remaining[idx];
  assign dt_ge = (cmd.amount >= rem);
  assign dt_le = (cmd.amount <= rem);
  assign sum = {1'b0, slot_remaining[tgt]} + {1'b0, cmd.amount};
  assign chain_time = sum[TB] ? '1 : sum[TB-1:0];

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = mmtt_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx = SB'(i);
      end
    end
  end

  // Control and outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      slot_valid <= '0;
      event_valid <= 1'b0;
      idx <= '0;
    end else begin
      event_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cmd <= q_head;
            idx <= '0;
            state <= (q_head.func == mmtt_pkg::FN_TICK) ? ST_SWEEP : ST_EXEC;
          end
        end
        ST_SWEEP: begin
          // One slot per cycle; done marker after the last
          if (slot_valid[idx] && !slot_paused[idx]) begin
            priority case (slot_mode[idx])
              mmtt_pkg::MODE_DURATION: begin
                if (dt_le) begin
                  slot_remaining[idx] <= rem - cmd.amount;
                  event_valid <= 1'b1;
                  event_kind <= mmtt_pkg::EV_DURATION;
                  event_slot <= 4'(idx);
                  last_of_run <= 1'b0;
                end else begin
                  slot_valid[idx] <= 1'b0;
                end
              end
              mmtt_pkg::MODE_PERIODIC: begin
                if (dt_ge) begin
                  slot_remaining[idx] <= slot_period[idx];
                  event_valid <= 1'b1;
                  event_kind <= mmtt_pkg::EV_FIRED;
                  event_slot <= 4'(idx);
                  last_of_run <= 1'b0;
                end else begin
                  slot_remaining[idx] <= rem - cmd.amount;
                end
              end
              default: begin
                if (dt_ge) begin
                  slot_valid[idx] <= 1'b0;
                  event_valid <= 1'b1;
                  event_kind <= mmtt_pkg::EV_FIRED;
                  event_slot <= 4'(idx);
                  last_of_run <= 1'b0;
                end else begin
                  slot_remaining[idx] <= rem - cmd.amount;
                end
              end
            endcase
          end
          if (idx == SB'(mmtt_pkg::SLOTS - 1)) begin
            state <= ST_EXEC;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: begin
          // Single-result commands, and the tick done marker
          event_valid <= 1'b1;
          last_of_run <= 1'b1;
          event_kind <= mmtt_pkg::EV_REJECT;
          event_slot <= '0;
          state <= ST_IDLE;
          unique case (cmd.func)
            mmtt_pkg::FN_TICK: begin
              event_kind <= mmtt_pkg::EV_DONE;
            end
            mmtt_pkg::FN_ONCE, mmtt_pkg::FN_DUR, mmtt_pkg::FN_PER,
            mmtt_pkg::FN_CHAIN: begin
              if (free_found && (cmd.func != mmtt_pkg::FN_CHAIN
                  || (known && !slot_paused[tgt]))) begin
                slot_valid[free_idx] <= 1'b1;
                slot_paused[free_idx] <= 1'b0;
                slot_mode[free_idx] <= (cmd.func == mmtt_pkg::FN_CHAIN)
                    ? mmtt_pkg::MODE_ONCE : cmd.func[1:0];
                slot_remaining[free_idx] <= (cmd.func == mmtt_pkg::FN_CHAIN)
                    ? chain_time : cmd.amount;
                slot_period[free_idx] <= (cmd.func == mmtt_pkg::FN_CHAIN)
                    ? chain_time : cmd.amount;
                event_kind <= mmtt_pkg::EV_ACCEPT;
                event_slot <= 4'(free_idx);
              end
            end
            mmtt_pkg::FN_CANCEL: begin
              if (known) begin
                slot_valid[tgt] <= 1'b0;
                event_kind <= mmtt_pkg::EV_ACCEPT;
                event_slot <= cmd.target_slot;
              end
            end
            mmtt_pkg::FN_PAUSE: begin
              if (known && !slot_paused[tgt]) begin
                slot_paused[tgt] <= 1'b1;
                event_kind <= mmtt_pkg::EV_ACCEPT;
                event_slot <= cmd.target_slot;
              end
            end
            default: begin
              if (known && slot_paused[tgt]) begin
                slot_paused[tgt] <= 1'b0;
                event_kind <= mmtt_pkg::EV_ACCEPT;
                event_slot <= cmd.target_slot;
              end
            end
          endcase
        end
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/multi_mode_task_timer.sv
// Top level of the multi-mode task timer
// A command is queued by the front end; the back end then takes it from the
// queue in its idle state and executes it in its exec state. A tick sweeps
// the slot table one slot per cycle and gives its fired/duration results
// in slot order, followed by a done marker.
// Results appear on event_valid for one cycle each and cannot be stalled;
// busy rises only when the two-entry command queue is full.
`default_nettype none
`include "multi_mode_task_timer_macros.svh"
module multi_mode_task_timer (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic [2:0] func,
  input wire logic [3:0] target_slot,
  input wire logic [31:0] amount,
  output logic busy,
  output logic event_valid,
  output logic [2:0] event_kind,
  output logic [3:0] event_slot,
  output logic last_of_run
);
  logic q_valid;
  logic q_pop;
  mmtt_pkg::cmd_t q_head;

  mmtt_front u_front (
    .clk(clk), .rst(rst), .start(start), .func(func),
    .target_slot(target_slot), .amount(amount), .busy(busy),
    .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop)
  );

  mmtt_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .event_valid(event_valid), .event_kind(event_kind),
    .event_slot(event_slot), .last_of_run(last_of_run)
  );

  // A pop only happens with something queued
  `MMTT_ASSERT_IMPL(a_pop_nonempty, clk, rst, q_pop, q_valid)
  // A done marker always closes its run
  `MMTT_ASSERT_IMPL(a_done_last, clk, rst,
    event_valid && event_kind == mmtt_pkg::EV_DONE, last_of_run)
  // Never two pops on consecutive cycles
  `MMTT_ASSERT_NEXT(a_pop_gap, clk, rst, q_pop, !q_pop)
endmodule
`default_nettype wire

FILE: test/mmtt_checker.sv
// Checker for the multi-mode task timer: timer table predictor and event comparison
`timescale 1ns / 1ps
`default_nettype none
module mmtt_checker
  import mmtt_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic [2:0] func,
  input wire logic [3:0] target_slot,
  input wire logic [31:0] amount,
  input wire logic event_valid,
  input wire logic [2:0] event_kind,
  input wire logic [3:0] event_slot,
  input wire logic last_of_run,
  output int errors,
  output int pending,
  output logic [SLOTS-1:0] live_slots
);
  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] slot;
    logic last;
  } timer_event_t;

  // Predicted timer table
  logic [SLOTS-1:0] t_valid;
  logic [1:0] t_mode [SLOTS];
  logic [SLOTS-1:0] t_paused;
  logic [TIME_BITS-1:0] t_remain [SLOTS];
  logic [TIME_BITS-1:0] t_period [SLOTS];

  timer_event_t expected_events[$];

  assign pending = expected_events.size();
  assign live_slots = t_valid;

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH %0t: %s", $realtime, what);
  endtask

  function automatic void post_event(input logic [2:0] k, input logic [3:0] s,
                                     input logic l);
    timer_event_t e;
    e.kind = k;
    e.slot = s;
    e.last = l;
    expected_events.insert(expected_events.size(), e);
  endfunction

  // Lowest free slot takes a new timer
  function automatic void allocate_timer(input logic [1:0] mode,
                                         input logic [TIME_BITS-1:0] t);
    int free_idx;
    free_idx = -1;
    for (int s = SLOTS - 1; s >= 0; s--)
      if (!t_valid[s]) free_idx = s;
    if (free_idx < 0) begin
      post_event(EV_REJECT, 4'd0, 1'b1);
    end else begin
      t_valid[free_idx] = 1'b1;
      t_mode[free_idx] = mode;
      t_paused[free_idx] = 1'b0;
      t_remain[free_idx] = t;
      t_period[free_idx] = t;
      post_event(EV_ACCEPT, 4'(free_idx), 1'b1);
    end
  endfunction

  // Sweep all slots in order for one tick
  function automatic void tick_table(input logic [TIME_BITS-1:0] dt);
    for (int s = 0; s < SLOTS; s++) begin
      if (t_valid[s] && !t_paused[s]) begin
        if (t_mode[s] == MODE_DURATION) begin
          if (dt <= t_remain[s]) begin
            t_remain[s] = t_remain[s] - dt;
            post_event(EV_DURATION, 4'(s), 1'b0);
          end else begin
            t_valid[s] = 1'b0;
          end
        end else if (dt >= t_remain[s]) begin
          if (t_mode[s] == MODE_PERIODIC) t_remain[s] = t_period[s];
          else t_valid[s] = 1'b0;
          post_event(EV_FIRED, 4'(s), 1'b0);
        end else begin
          t_remain[s] = t_remain[s] - dt;
        end
      end
    end
    post_event(EV_DONE, 4'd0, 1'b1);
  endfunction

  function automatic void predict_command(input logic [2:0] f, input logic [3:0] tgt,
                                          input logic [31:0] amt);
    logic known;
    logic [TIME_BITS:0] sum;
    known = t_valid[tgt];
    case (f)
      FN_TICK: tick_table(amt);
      FN_ONCE: allocate_timer(MODE_ONCE, amt);
      FN_DUR: allocate_timer(MODE_DURATION, amt);
      FN_PER: allocate_timer(MODE_PERIODIC, amt);
      FN_CHAIN: begin
        if (!known || t_paused[tgt]) begin
          post_event(EV_REJECT, 4'd0, 1'b1);
        end else begin
          sum = {1'b0, t_remain[tgt]} + {1'b0, amt};
          allocate_timer(MODE_ONCE, sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0]);
        end
      end
      FN_CANCEL: begin
        if (!known) begin
          post_event(EV_REJECT, 4'd0, 1'b1);
        end else begin
          t_valid[tgt] = 1'b0;
          post_event(EV_ACCEPT, tgt, 1'b1);
        end
      end
      FN_PAUSE: begin
        if (!known || t_paused[tgt]) begin
          post_event(EV_REJECT, 4'd0, 1'b1);
        end else begin
          t_paused[tgt] = 1'b1;
          post_event(EV_ACCEPT, tgt, 1'b1);
        end
      end
      default: begin
        if (!known || !t_paused[tgt]) begin
          post_event(EV_REJECT, 4'd0, 1'b1);
        end else begin
          t_paused[tgt] = 1'b0;
          post_event(EV_ACCEPT, tgt, 1'b1);
        end
      end
    endcase
  endfunction

  // Predict on each command transfer, compare each event transfer
  always @(posedge clk) begin
    timer_event_t want;
    if (rst) begin
      t_valid = '0;
      t_paused = '0;
      errors = 0;
      expected_events.delete();
    end else begin
      if (event_valid) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event kind %0d slot %0d",
                                    event_kind, event_slot));
        end else begin
          want = expected_events.pop_front();
          if (event_kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", event_kind, want.kind));
          if (event_slot !== want.slot)
            report_mismatch($sformatf("slot %0d, want %0d", event_slot, want.slot));
          if (last_of_run !== want.last)
            report_mismatch($sformatf("last %0d, want %0d", last_of_run, want.last));
        end
      end
      if (start && !busy) predict_command(func, target_slot, amount);
    end
  end
endmodule
`default_nettype wire

FILE: test/tb_multi_mode_task_timer.sv
// Testbench top for the multi-mode task timer: stimulus, watchdog and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_multi_mode_task_timer;
  import mmtt_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [2:0] func = FN_TICK;
  logic [3:0] target_slot = '0;
  logic [31:0] amount = '0;
  logic busy, event_valid, last_of_run;
  logic [2:0] event_kind;
  logic [3:0] event_slot;
  int errors, pending;
  logic [SLOTS-1:0] live_slots;
  int idle_pct;
  int quiet_cycles;

  always #4 clk = ~clk;

  multi_mode_task_timer u_top (
    .clk, .rst, .start, .func, .target_slot, .amount, .busy,
    .event_valid, .event_kind, .event_slot, .last_of_run
  );

  mmtt_checker u_checker (
    .clk, .rst, .start, .busy, .func, .target_slot, .amount,
    .event_valid, .event_kind, .event_slot, .last_of_run,
    .errors, .pending, .live_slots
  );

  // Watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || event_valid || (start && !busy)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_multi_mode_task_timer failed");
        $finish;
      end
    end
  end

  // One command transfer, with random idle gaps before it
  // start stays high on return; drain() or an idle gap in the next command drops it
  task automatic send_command(input logic [2:0] f, input logic [3:0] tgt,
                              input logic [31:0] amt);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    func <= f;
    target_slot <= tgt;
    amount <= amt;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_time();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(12);
    endcase
  endfunction

  function automatic logic [3:0] random_target();
    int pick;
    if ($urandom_range(4) == 0 || live_slots == '0) return 4'($urandom_range(15));
    do pick = $urandom_range(SLOTS - 1); while (!live_slots[pick]);
    return 4'(pick);
  endfunction

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int roll;
    idle_pct = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: rejects on empty table, all modes, extremes, fill and overflow
    send_command(FN_CANCEL, 4'd3, 32'd0);
    send_command(FN_PAUSE, 4'd15, 32'd0);
    send_command(FN_RESUME, 4'd0, 32'd0);
    send_command(FN_CHAIN, 4'd0, 32'd5);
    send_command(FN_TICK, 4'd0, 32'd0);
    send_command(FN_ONCE, 4'd0, 32'd2);
    send_command(FN_DUR, 4'd0, 32'd3);
    send_command(FN_PER, 4'd0, 32'd0);
    send_command(FN_PER, 4'd0, 32'hFFFF_FFFF);
    send_command(FN_CHAIN, 4'd3, 32'hFFFF_FFFF);
    send_command(FN_PAUSE, 4'd1, 32'd0);
    send_command(FN_PAUSE, 4'd1, 32'd0);
    send_command(FN_TICK, 4'd0, 32'd1);
    send_command(FN_TICK, 4'd0, 32'd3);
    send_command(FN_RESUME, 4'd1, 32'd0);
    send_command(FN_RESUME, 4'd1, 32'd0);
    send_command(FN_TICK, 4'd0, 32'hFFFF_FFFF);
    repeat (16) send_command(FN_ONCE, 4'd0, 32'd7);
    send_command(FN_DUR, 4'd0, 32'd1);
    send_command(FN_CHAIN, 4'd0, 32'd1);
    send_command(FN_TICK, 4'd0, 32'd9);
    // Sender holds off until every event is in
    drain();

    // Random phases with different idle rates
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 72 : (phase == 3) ? 16 : 0;
      for (int i = 0; i < 48; i++) begin
        roll = $urandom_range(99);
        if (roll < 22) send_command(FN_TICK, 4'($urandom), random_time());
        else if (roll < 50)
          send_command(3'($urandom_range(FN_PER, FN_ONCE)), 4'($urandom), random_time());
        else send_command(3'($urandom_range(FN_RESUME, FN_CHAIN)), random_target(),
                          random_time());
      end
      if (phase == 2) drain();
    end

    drain();
    if (errors == 0) begin
      $display("tb_multi_mode_task_timer passed");
    end else begin
      $display("tb_multi_mode_task_timer failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/mmtt_pkg.sv
rtl/mmtt_front.sv
rtl/mmtt_back.sv
rtl/multi_mode_task_timer.sv
test/mmtt_checker.sv
test/tb_multi_mode_task_timer.sv
